// File: hw/rtl/imudr_pkg.sv
// Shared types, constants and helpers of the IMU dead-reckoning step unit.
package imudr_pkg;

    // Angle format and phase extraction
    localparam int ANGLE_FRAC = 12;
    localparam int PH_LSB     = 34 + ANGLE_FRAC;

    // Digit-serial multiplier geometry
    localparam int XW   = 41;
    localparam int YW   = 68;
    localparam int ACCW = 47;
    localparam int SUMW = ACCW + 1;
    localparam int PW   = ACCW + YW;

    localparam logic [15:0] CAL_RESET       = 16'd300;
    localparam logic [63:0] TWO_OVER_PI_Q64 = 64'hA2F9_836E_4E44_152A;

    // Sine polynomial coefficients, Q2.30
    localparam logic [31:0] K1 = 32'd1686629713;
    localparam logic [31:0] K3 = 32'd693598668;
    localparam logic [31:0] K5 = 32'd85569306;
    localparam logic [31:0] K7 = 32'd5026995;
    localparam logic [31:0] K9 = 32'd172272;

    typedef struct packed {
        logic signed [15:0] accel_x;
        logic signed [15:0] accel_y;
        logic signed [15:0] accel_z;
        logic signed [15:0] gyro_x;
        logic signed [15:0] gyro_y;
        logic signed [15:0] gyro_z;
    } imu_sample_t;

    typedef struct packed {
        logic signed [47:0] pos_x;
        logic signed [47:0] pos_y;
        logic signed [47:0] pos_z;
    } imu_pos_t;

    // Multiplier operand length: 4, 9 or 17 digits of the Y operand
    typedef enum logic [1:0] {
        MUL_SHORT,
        MUL_MID,
        MUL_LONG
    } mul_mode_t;

    // Q1.15 operands of the rotation matrix products
    typedef enum logic [2:0] {
        Q_SP,
        Q_CP,
        Q_SR,
        Q_CR,
        Q_SY,
        Q_CY,
        Q_SPC,
        Q_SPS
    } q15_src_t;

    typedef struct packed {
        q15_src_t a;
        q15_src_t b;
    } mat_op_t;

    // Index of the last digit for each operand length
    function automatic logic [4:0] last_digit(input mul_mode_t mode);
        logic [4:0] r;
        unique case (mode)
            MUL_SHORT: r = 5'd3;
            MUL_MID:   r = 5'd8;
            MUL_LONG:  r = 5'd16;
            default:   r = 5'd3;
        endcase
        return r;
    endfunction

    // Horner coefficient taken after each polynomial step
    function automatic logic [31:0] horner_k(input logic [2:0] step);
        logic [31:0] r;
        unique case (step)
            3'd1:    r = K7;
            3'd2:    r = K5;
            3'd3:    r = K3;
            3'd4:    r = K1;
            default: r = '0;
        endcase
        return r;
    endfunction

    // Product schedule of the rotation matrix
    function automatic mat_op_t mat_op(input logic [3:0] idx);
        mat_op_t r;
        unique case (idx)
            4'd0:    r = '{a: Q_CY,  b: Q_SP};
            4'd1:    r = '{a: Q_SY,  b: Q_SP};
            4'd2:    r = '{a: Q_CY,  b: Q_CP};
            4'd3:    r = '{a: Q_SPC, b: Q_SR};
            4'd4:    r = '{a: Q_SY,  b: Q_CR};
            4'd5:    r = '{a: Q_SPC, b: Q_CR};
            4'd6:    r = '{a: Q_SY,  b: Q_SR};
            4'd7:    r = '{a: Q_SY,  b: Q_CP};
            4'd8:    r = '{a: Q_SPS, b: Q_SR};
            4'd9:    r = '{a: Q_CY,  b: Q_CR};
            4'd10:   r = '{a: Q_SPS, b: Q_CR};
            4'd11:   r = '{a: Q_CY,  b: Q_SR};
            4'd12:   r = '{a: Q_CP,  b: Q_SR};
            4'd13:   r = '{a: Q_CP,  b: Q_CR};
            default: r = '{a: Q_SP,  b: Q_SP};
        endcase
        return r;
    endfunction

    function automatic logic [31:0] abs32(input logic signed [31:0] v);
        return v[31] ? (32'd0 - v) : v;
    endfunction

    function automatic logic signed [39:0] sat40(input logic signed [41:0] v);
        logic signed [39:0] r;
        if (v[41:39] == 3'b000 || v[41:39] == 3'b111) begin
            r = v[39:0];
        end else begin
            r = v[41] ? {1'b1, 39'd0} : {1'b0, {39{1'b1}}};
        end
        return r;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
        logic signed [31:0] r;
        if (v[33:31] == 3'b000 || v[33:31] == 3'b111) begin
            r = v[31:0];
        end else begin
            r = v[33] ? {1'b1, 31'd0} : {1'b0, {31{1'b1}}};
        end
        return r;
    endfunction

    function automatic logic signed [47:0] sat48(input logic signed [49:0] v);
        logic signed [47:0] r;
        if (v[49:47] == 3'b000 || v[49:47] == 3'b111) begin
            r = v[47:0];
        end else begin
            r = v[49] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
        end
        return r;
    endfunction

endpackage

// File: hw/rtl/imu_dead_reckoning_step_unit.sv
// IMU dead-reckoning step: calibration, attitude and position integration.
//
//  channel  direction  beat                      handshake
//  s_       in         imu_sample_t (6 x 16 bit) s_valid / s_ready
//  m_       out        imu_pos_t (3 x 48 bit)    m_valid / m_ready
//  cfg_     in         calibration_count, 16 bit cfg_valid / cfg_ready
//
// A calibration beat is summed in ST_IDLE; the beat that ends calibration adds a
// bit-serial division pass (six 32-step divisions).
// A run beat uses the single 4-bit digit-serial multiplier,
// shared by the phase, sine/cosine, matrix and rotation products.
// Synchronous active-low reset; cfg_ready is always high.
// A finished result waits in the output register while the next beat is taken;
// the final write-back stalls only if that register is still full.
module imu_dead_reckoning_step_unit (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  imudr_pkg::imu_sample_t s_data,
    output logic                   m_valid,
    input  logic                   m_ready,
    output imudr_pkg::imu_pos_t    m_data,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [15:0]            cfg_data
);
    import imudr_pkg::*;

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_DIV   = 7'b0000010,
        ST_PHASE = 7'b0000100,
        ST_TRIG  = 7'b0001000,
        ST_MAT   = 7'b0010000,
        ST_MV    = 7'b0100000,
        ST_EMIT  = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    // Calibration and integration state
    logic [15:0]        cal_count_reg;
    logic               cal_done_reg;
    logic [15:0]        seen_cnt_reg;
    logic signed [31:0] sum_reg [6];
    logic signed [15:0] off_reg [6];
    logic signed [39:0] vel_reg [3];
    logic signed [31:0] ang_reg [3];
    logic signed [47:0] pos_reg [3];

    // Divider
    logic [2:0]  div_axis_reg;
    logic [4:0]  div_bit_reg;
    logic [15:0] div_rem_reg;
    logic [31:0] div_dvd_reg;
    logic [15:0] div_n_reg;

    // Sine / cosine
    logic [1:0]         ang_idx_reg;
    logic               cs_reg;
    logic [2:0]         step_reg;
    logic [31:0]        phase_reg;
    logic [30:0]        u2_reg;
    logic [31:0]        p_reg;
    logic signed [15:0] sin_reg [3];
    logic signed [15:0] cos_reg [3];

    // Matrix and rotation
    logic [3:0]         mat_idx_reg;
    logic signed [15:0] prd_reg [14];
    logic [1:0]         row_reg;
    logic [1:0]         col_reg;
    logic signed [59:0] sacc_reg;

    logic     m_valid_reg;
    imu_pos_t m_data_reg;

    // Combinational
    logic signed [15:0] samp [6];
    logic signed [31:0] sum_next [6];
    logic signed [39:0] vel_upd [3];
    logic signed [31:0] ang_upd [3];
    logic [16:0]        n_cnt;
    logic               cal_end;

    logic [16:0] div_rem_t;
    logic        div_ge;
    logic [16:0] div_rem_sub;
    logic [31:0] div_q;
    logic [31:0] div_q_s;
    logic [2:0]  div_axis_nx;

    logic signed [31:0] ang_sel;
    logic [31:0]        ph_raw;
    logic [31:0]        ph_eff;
    logic [30:0]        u_val;
    logic [31:0]        res30;
    logic [32:0]        fin_sum;
    logic [17:0]        fin_sh;
    logic [15:0]        fin_mag;
    logic signed [15:0] trig_val;

    mat_op_t            mop;
    logic signed [15:0] src_a;
    logic signed [15:0] src_b;
    logic signed [17:0] m_sel;
    logic signed [59:0] mv_sum;
    logic signed [59:0] mv_shift;
    logic signed [47:0] pos_sat;

    logic                 mul_req;
    mul_mode_t            mul_mode;
    logic signed [XW-1:0] mul_x;
    logic [YW-1:0]        mul_y;
    logic                 mul_done;
    logic signed [PW-1:0] mul_prod;

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    // Sample unpacking, calibration sums and accumulator updates
    always_comb begin
        samp[0] = s_data.accel_x;
        samp[1] = s_data.accel_y;
        samp[2] = s_data.accel_z;
        samp[3] = s_data.gyro_x;
        samp[4] = s_data.gyro_y;
        samp[5] = s_data.gyro_z;
        for (int i = 0; i < 6; i++) begin
            sum_next[i] = sum_reg[i] + 32'(samp[i]);
        end
        for (int i = 0; i < 3; i++) begin
            vel_upd[i] = sat40(42'(vel_reg[i]) + 42'(samp[i]) - 42'(off_reg[i]));
            ang_upd[i] = sat32(34'(ang_reg[i]) + 34'(samp[i+3]) - 34'(off_reg[i+3]));
        end
        n_cnt   = {1'b0, seen_cnt_reg} + 17'd1;
        cal_end = (n_cnt >= {1'b0, cal_count_reg});
    end

    // Restoring divider step, one quotient bit a cycle
    always_comb begin
        div_rem_t   = {div_rem_reg, div_dvd_reg[31]};
        div_ge      = (div_rem_t >= {1'b0, div_n_reg});
        div_rem_sub = div_rem_t - {1'b0, div_n_reg};
        div_q       = {div_dvd_reg[30:0], div_ge};
        div_q_s     = sum_reg[div_axis_reg][31] ? (32'd0 - div_q) : div_q;
        div_axis_nx = (div_axis_reg == 3'd5) ? 3'd0 : div_axis_reg + 3'd1;
    end

    // Phase, quadrant fold and sine rounding
    always_comb begin
        ang_sel  = ang_reg[ang_idx_reg];
        ph_raw   = mul_prod[PH_LSB+31:PH_LSB];
        ph_eff   = phase_reg + (cs_reg ? 32'h4000_0000 : 32'd0);
        u_val    = ph_eff[30] ? (31'h4000_0000 - {1'b0, ph_eff[29:0]})
                              : {1'b0, ph_eff[29:0]};
        res30    = mul_prod[61:30];
        fin_sum  = {1'b0, res30} + 33'd16384;
        fin_sh   = fin_sum[32:15];
        fin_mag  = (fin_sh > 18'd32767) ? 16'd32767 : fin_sh[15:0];
        trig_val = ph_eff[31] ? (16'sd0 - $signed(fin_mag)) : $signed(fin_mag);
    end

    // Matrix product operands
    always_comb begin
        mop = mat_op(mat_idx_reg);
        unique case (mop.a)
            Q_SP:    src_a = sin_reg[0];
            Q_CP:    src_a = cos_reg[0];
            Q_SR:    src_a = sin_reg[1];
            Q_CR:    src_a = cos_reg[1];
            Q_SY:    src_a = sin_reg[2];
            Q_CY:    src_a = cos_reg[2];
            Q_SPC:   src_a = prd_reg[0];
            Q_SPS:   src_a = prd_reg[1];
            default: src_a = '0;
        endcase
        unique case (mop.b)
            Q_SP:    src_b = sin_reg[0];
            Q_CP:    src_b = cos_reg[0];
            Q_SR:    src_b = sin_reg[1];
            Q_CR:    src_b = cos_reg[1];
            Q_SY:    src_b = sin_reg[2];
            Q_CY:    src_b = cos_reg[2];
            Q_SPC:   src_b = prd_reg[0];
            Q_SPS:   src_b = prd_reg[1];
            default: src_b = '0;
        endcase
    end

    // Rotation matrix element for the current row and column
    always_comb begin
        unique case ({row_reg, col_reg})
            4'b0000: m_sel = 18'(prd_reg[2]);
            4'b0001: m_sel = 18'(prd_reg[3]) - 18'(prd_reg[4]);
            4'b0010: m_sel = 18'(prd_reg[5]) + 18'(prd_reg[6]);
            4'b0100: m_sel = 18'(prd_reg[7]);
            4'b0101: m_sel = 18'(prd_reg[8]) + 18'(prd_reg[9]);
            4'b0110: m_sel = 18'(prd_reg[10]) - 18'(prd_reg[11]);
            4'b1000: m_sel = 18'sd0 - 18'(sin_reg[0]);
            4'b1001: m_sel = 18'(prd_reg[12]);
            4'b1010: m_sel = 18'(prd_reg[13]);
            default: m_sel = '0;
        endcase
        mv_sum   = sacc_reg + 60'(mul_prod);
        mv_shift = mv_sum >>> 15;
        pos_sat  = sat48(50'(pos_reg[row_reg]) + 50'(mv_shift));
    end

    // Multiplier operand selection
    always_comb begin
        mul_req  = 1'b0;
        mul_mode = MUL_SHORT;
        mul_x    = '0;
        mul_y    = '0;
        unique case (state_reg)
            ST_PHASE: begin
                mul_req  = 1'b1;
                mul_mode = MUL_LONG;
                mul_x    = $signed(XW'(abs32(ang_sel)));
                mul_y    = YW'(TWO_OVER_PI_Q64);
            end
            ST_TRIG: begin
                mul_req  = 1'b1;
                mul_mode = MUL_MID;
                mul_x    = (step_reg == 3'd0 || step_reg == 3'd5) ? $signed(XW'(u_val))
                                                                  : $signed(XW'(u2_reg));
                if (step_reg == 3'd0) begin
                    mul_y = YW'(u_val);
                end else if (step_reg == 3'd1) begin
                    mul_y = YW'(K9);
                end else begin
                    mul_y = YW'(p_reg);
                end
            end
            ST_MAT: begin
                mul_req  = 1'b1;
                mul_mode = MUL_SHORT;
                mul_x    = XW'(src_a);
                mul_y    = YW'(src_b);
            end
            ST_MV: begin
                mul_req  = 1'b1;
                mul_mode = MUL_MID;
                mul_x    = XW'(vel_reg[col_reg]);
                mul_y    = YW'(m_sel);
            end
            default: begin
                mul_req = 1'b0;
            end
        endcase
    end

    imudr_serial_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mul_req),
        .mode    (mul_mode),
        .x       (mul_x),
        .y       (mul_y),
        .done    (mul_done),
        .product (mul_prod)
    );

    // Sequencer next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (cal_done_reg) begin
                        state_next = ST_PHASE;
                    end else if (cal_end) begin
                        state_next = ST_DIV;
                    end
                end
            end
            ST_DIV: begin
                if (div_bit_reg == 5'd31 && div_axis_reg == 3'd5) begin
                    state_next = ST_IDLE;
                end
            end
            ST_PHASE: begin
                if (mul_done) begin
                    state_next = ST_TRIG;
                end
            end
            ST_TRIG: begin
                if (mul_done && step_reg == 3'd5 && cs_reg) begin
                    state_next = (ang_idx_reg == 2'd2) ? ST_MAT : ST_PHASE;
                end
            end
            ST_MAT: begin
                if (mul_done && mat_idx_reg == 4'd13) begin
                    state_next = ST_MV;
                end
            end
            ST_MV: begin
                if (mul_done && col_reg == 2'd2 && row_reg == 2'd2) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            cal_count_reg <= CAL_RESET;
            cal_done_reg  <= 1'b0;
            seen_cnt_reg  <= '0;
            for (int i = 0; i < 6; i++) begin
                sum_reg[i] <= '0;
                off_reg[i] <= '0;
            end
            for (int i = 0; i < 3; i++) begin
                vel_reg[i] <= '0;
                ang_reg[i] <= '0;
                pos_reg[i] <= '0;
            end
            div_axis_reg <= '0;
            div_bit_reg  <= '0;
            ang_idx_reg  <= '0;
            cs_reg       <= 1'b0;
            step_reg     <= '0;
            mat_idx_reg  <= '0;
            row_reg      <= '0;
            col_reg      <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid) begin
                cal_count_reg <= cfg_data;
            end
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                // Take a beat: sum during calibration, else integrate
                ST_IDLE: begin
                    if (s_valid) begin
                        if (!cal_done_reg) begin
                            for (int i = 0; i < 6; i++) begin
                                sum_reg[i] <= sum_next[i];
                            end
                            seen_cnt_reg <= n_cnt[15:0];
                            if (cal_end) begin
                                cal_done_reg <= 1'b1;
                                div_axis_reg <= '0;
                                div_bit_reg  <= '0;
                                div_rem_reg  <= '0;
                                div_dvd_reg  <= abs32(sum_next[0]);
                                div_n_reg    <= n_cnt[15:0];
                            end
                        end else begin
                            for (int i = 0; i < 3; i++) begin
                                vel_reg[i] <= vel_upd[i];
                                ang_reg[i] <= ang_upd[i];
                            end
                            ang_idx_reg <= '0;
                        end
                    end
                end
                // Bias division, truncating toward zero
                ST_DIV: begin
                    div_rem_reg <= div_ge ? div_rem_sub[15:0] : div_rem_t[15:0];
                    div_dvd_reg <= div_q;
                    div_bit_reg <= div_bit_reg + 5'd1;
                    if (div_bit_reg == 5'd31) begin
                        off_reg[div_axis_reg] <= div_q_s[15:0];
                        div_axis_reg          <= div_axis_nx;
                        div_rem_reg           <= '0;
                        div_dvd_reg           <= abs32(sum_reg[div_axis_nx]);
                    end
                end
                ST_PHASE: begin
                    if (mul_done) begin
                        phase_reg <= ang_sel[31] ? (32'd0 - ph_raw) : ph_raw;
                        cs_reg    <= 1'b0;
                        step_reg  <= '0;
                    end
                end
                // Horner evaluation, sine then cosine of each angle
                ST_TRIG: begin
                    if (mul_done) begin
                        if (step_reg == 3'd0) begin
                            u2_reg   <= res30[30:0];
                            step_reg <= step_reg + 3'd1;
                        end else if (step_reg == 3'd5) begin
                            step_reg <= '0;
                            if (!cs_reg) begin
                                sin_reg[ang_idx_reg] <= trig_val;
                                cs_reg               <= 1'b1;
                            end else begin
                                cos_reg[ang_idx_reg] <= trig_val;
                                cs_reg               <= 1'b0;
                                ang_idx_reg          <= ang_idx_reg + 2'd1;
                                mat_idx_reg          <= '0;
                            end
                        end else begin
                            p_reg    <= horner_k(step_reg) - res30;
                            step_reg <= step_reg + 3'd1;
                        end
                    end
                end
                ST_MAT: begin
                    if (mul_done) begin
                        prd_reg[mat_idx_reg] <= mul_prod[30:15];
                        mat_idx_reg          <= mat_idx_reg + 4'd1;
                        if (mat_idx_reg == 4'd13) begin
                            row_reg  <= '0;
                            col_reg  <= '0;
                            sacc_reg <= '0;
                        end
                    end
                end
                // Rotate velocity row by row, add into position
                ST_MV: begin
                    if (mul_done) begin
                        if (col_reg == 2'd2) begin
                            pos_reg[row_reg] <= pos_sat;
                            sacc_reg         <= '0;
                            col_reg          <= '0;
                            row_reg          <= row_reg + 2'd1;
                        end else begin
                            sacc_reg <= mv_sum;
                            col_reg  <= col_reg + 2'd1;
                        end
                    end
                end
                ST_EMIT: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg      <= 1'b1;
                        m_data_reg.pos_x <= pos_reg[0];
                        m_data_reg.pos_y <= pos_reg[1];
                        m_data_reg.pos_z <= pos_reg[2];
                    end
                end
                default: begin
                    m_valid_reg <= m_valid_reg;
                end
            endcase
        end
    end

endmodule

// File: hw/rtl/imudr_serial_mul.sv
// Digit-serial signed multiplier, four bits of the Y operand per cycle.
module imudr_serial_mul (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 req,
    input  imudr_pkg::mul_mode_t                 mode,
    input  logic signed [imudr_pkg::XW-1:0]      x,
    input  logic        [imudr_pkg::YW-1:0]      y,
    output logic                                 done,
    output logic signed [imudr_pkg::PW-1:0]      product
);
    import imudr_pkg::*;

    logic                   busy_reg;
    logic                   done_reg;
    logic [4:0]             cnt_reg;
    logic [4:0]             last_reg;
    mul_mode_t              mode_reg;
    logic signed [XW-1:0]   x_reg;
    logic [YW-1:0]          y_reg;
    logic signed [ACCW-1:0] acc_reg;
    logic [YW-1:0]          low_reg;

    logic                   start;
    logic                   last;
    logic signed [4:0]      digit;
    logic signed [XW+4:0]   term;
    logic signed [SUMW-1:0] sum;
    logic signed [ACCW-1:0] acc_next;

    assign start = req && !busy_reg && !done_reg;
    assign last  = (cnt_reg == last_reg);
    assign done  = done_reg;

    // One digit step: top digit is signed, the others unsigned
    always_comb begin
        digit    = last ? $signed({y_reg[3], y_reg[3:0]}) : $signed({1'b0, y_reg[3:0]});
        term     = x_reg * digit;
        sum      = SUMW'(acc_reg) + SUMW'(term);
        acc_next = ACCW'(sum >>> 4);
    end

    // Control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 5'd1;
                if (last) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Operand and partial product shift registers
    always_ff @(posedge aclk) begin
        if (start) begin
            x_reg    <= x;
            y_reg    <= y;
            mode_reg <= mode;
            last_reg <= last_digit(mode);
            acc_reg  <= '0;
            low_reg  <= '0;
        end else if (busy_reg) begin
            acc_reg <= acc_next;
            low_reg <= {sum[3:0], low_reg[YW-1:4]};
            y_reg   <= y_reg >> 4;
        end
    end

    // Product alignment by operand length
    always_comb begin
        unique case (mode_reg)
            MUL_LONG:  product = $signed({acc_reg, low_reg});
            MUL_MID:   product = PW'($signed({acc_reg, low_reg[YW-1 -: 36]}));
            MUL_SHORT: product = PW'($signed({acc_reg, low_reg[YW-1 -: 16]}));
            default:   product = '0;
        endcase
    end

endmodule
